// ----- hdl/acbd_pkg.sv -----
// ----------------------------------------------------------------------------
// acbd_pkg - shared types, constants and byte functions
// S-box tables, GF(2^8) helpers and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package acbd_pkg;

    localparam logic [7:0] KEY_MASK = 8'hA5;
    localparam logic [7:0] IV_MASK  = 8'h3C;
    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] POLY_LOW  = 8'h1B;
    localparam logic [7:0] RCON_LAST = 8'h36;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_WORDS  = 2 * (NUM_ROUNDS + 1);

    localparam logic [0:0] CFG_SEED_LOW  = 1'b0;
    localparam logic [0:0] CFG_SEED_HIGH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_OUT    = 4'b1000
    } t_state;

    typedef struct packed {
        logic [63:0] plain_low;
        logic [63:0] plain_high;
        logic        message_end;
    } t_result;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ((a << 1) ^ POLY_LOW) : (a << 1);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[32*c +: 8];
            a1 = s[32*c + 8 +: 8];
            a2 = s[32*c + 16 +: 8];
            a3 = s[32*c + 24 +: 8];
            r[32*c +: 8]      = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
            r[32*c + 8 +: 8]  = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
            r[32*c + 16 +: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
            r[32*c + 24 +: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        logic [1:0] sc;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sc = 2'(c - r);
                t[8*(r + 4*c) +: 8] = INV_SBOX[s[8*(r + 4*int'(sc)) +: 8]];
            end
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/acbd_stream_if.sv -----
// ----------------------------------------------------------------------------
// acbd_stream_if - valid/ready channel carrying one item
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface acbd_stream_if #(
    parameter int W = 129
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/aes128_cbc_block_decryptor.sv -----
// ----------------------------------------------------------------------------
// aes128_cbc_block_decryptor - AES-128 CBC decryption of 128-bit blocks
// Equivalent inverse cipher with one shared round unit; key from seed.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_in      in   {last_block, first_block, cipher_high, cipher_low}
// m_out     out  {plain_low, plain_high, message_end} (t_result)
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
//
// A block goes through load, ten rounds through the shared round unit and the
// result; a first_block item first adds key expansion of eleven round keys, one
// round key a cycle, and a read back of key 0. Reset is synchronous; the
// round-key store is not cleared. The result waits in an output register
// until taken while the next item is taken and decrypted; that item holds in
// ST_OUT until the register is free.
`default_nettype none
module aes128_cbc_block_decryptor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    acbd_stream_if.sink      s_in,
    acbd_stream_if.source    m_out
);
    import acbd_pkg::*;

    t_state        r_state;
    logic [63:0]   r_seed_lo, r_seed_hi;
    logic [127:0]  r_chain, r_cipher, r_s;
    logic          r_last;
    logic [3:0]    r_round;
    logic [127:0]  r_rk [KEY_WORDS/2];
    logic [127:0]  r_rk_q;
    logic [3:0]    n_rk_addr;
    t_result       r_res;
    logic          r_out_v;

    logic [127:0]  w_seed, w_key;
    logic          w_kx_busy, w_kx_wr, w_kx_start;
    logic [3:0]    w_kx_idx;
    logic [127:0]  w_kx_key;
    logic [127:0]  w_rnd, w_fin;
    logic          w_take;
    logic          w_out_load;

    assign w_seed = {r_seed_hi, r_seed_lo};
    always_comb begin
        for (int i = 0; i < 16; i++) w_key[8*i +: 8] = w_seed[8*i +: 8] ^ KEY_MASK;
    end

    assign w_take     = s_in.valid && s_in.ready;
    assign w_kx_start = w_take && s_in.data[128];
    assign s_in.ready = (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_v || m_out.ready);

    acbd_key_expand u_kx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_kx_start),
        .i_key   (w_key),
        .o_busy  (w_kx_busy),
        .o_wr    (w_kx_wr),
        .o_wr_idx(w_kx_idx),
        .o_wr_key(w_kx_key)
    );

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED_LOW:  r_seed_lo <= i_cfg_data;
                CFG_SEED_HIGH: r_seed_hi <= i_cfg_data;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_seed_lo <= '0;
            r_seed_hi <= '0;
        end
    end

    // round-key memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_kx_wr) r_rk[w_kx_idx] <= w_kx_key;
        r_rk_q <= r_rk[n_rk_addr];
    end

    always_comb begin
        n_rk_addr = r_round;
        if (r_state == ST_EXPAND || r_state == ST_IDLE) n_rk_addr = 4'd0;
        else if (r_state == ST_ROUND) n_rk_addr = r_round + 4'd1;
    end

    assign w_rnd = inv_mix(inv_shift_sub(r_s ^ r_rk_q));
    assign w_fin = inv_shift_sub(r_s ^ r_rk_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_chain <= '0;
            r_round <= '0;
        end else begin
            if (w_out_load) r_out_v <= 1'b1;
            else if (m_out.valid && m_out.ready) r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_cipher <= s_in.data[127:0];
                        r_s      <= s_in.data[127:0];
                        r_last   <= s_in.data[129];
                        r_round  <= '0;
                        if (s_in.data[128]) begin
                            r_chain <= w_key ^ {16{IV_MASK}};
                            r_state <= ST_EXPAND;
                        end else begin
                            r_state <= ST_ROUND;
                        end
                    end
                end
                ST_EXPAND: begin
                    // key 0 is written last; read it the cycle after
                    if (!w_kx_busy) r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_round <= r_round + 4'd1;
                    if (r_round == 4'(NUM_ROUNDS - 1)) begin
                        r_s     <= w_fin;
                        r_state <= ST_OUT;
                    end else begin
                        r_s <= w_rnd;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (w_out_load) begin
                        r_res.plain_low   <= (r_s[63:0] ^ r_rk_q[63:0]) ^ r_chain[63:0];
                        r_res.plain_high  <= (r_s[127:64] ^ r_rk_q[127:64]) ^ r_chain[127:64];
                        r_res.message_end <= r_last;
                        r_chain <= r_cipher;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_out.valid = r_out_v;
    assign m_out.data  = r_res;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> (r_state == ST_IDLE)) else $error("ready outside idle");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_out.ready) |=> r_out_v) else $error("result lost");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_v && !m_out.ready) |=> (r_state == ST_OUT))
        else $error("result overwritten");
    a_kx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !w_kx_busy) else $error("rounds during expansion");
endmodule
`default_nettype wire

// ----- hdl/acbd_key_expand.sv -----
// ----------------------------------------------------------------------------
// acbd_key_expand - iterative AES-128 key expansion
// One encryption round key a cycle; writes decryption keys 10..0 in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module acbd_key_expand (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_key,
    output logic              o_busy,
    output logic              o_wr,
    output logic [3:0]        o_wr_idx,
    output logic [127:0]      o_wr_key
);
    import acbd_pkg::*;

    logic [127:0] r_key;
    logic [7:0]   r_rcon;
    logic [3:0]   r_step;
    logic         r_busy;
    logic [31:0]  w_rot;
    logic [127:0] w_next;

    always_comb begin
        w_rot = {SBOX[r_key[103:96]], SBOX[r_key[127:120]],
                 SBOX[r_key[119:112]], SBOX[r_key[111:104] ] ^ r_rcon};
        w_next[31:0]   = r_key[31:0] ^ w_rot;
        w_next[63:32]  = r_key[63:32] ^ w_next[31:0];
        w_next[95:64]  = r_key[95:64] ^ w_next[63:32];
        w_next[127:96] = r_key[127:96] ^ w_next[95:64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 4'd1;
            if (r_step == 4'(NUM_ROUNDS)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_rcon <= RCON_INIT;
        end else if (r_busy) begin
            r_key  <= w_next;
            r_rcon <= xtime(r_rcon);
        end
    end

    // round key i is decryption key 10-i; first and last stay plain
    assign o_busy   = r_busy;
    assign o_wr     = r_busy;
    assign o_wr_idx = 4'(NUM_ROUNDS) - r_step;
    assign o_wr_key = (r_step == 4'd0 || r_step == 4'(NUM_ROUNDS)) ? r_key : inv_mix(r_key);
endmodule
`default_nettype wire
